// ----- src/mts_pkg.sv -----
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants of the multi-timer scheduler.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int unsigned NumSlots   = 8;
  localparam int unsigned SlotW      = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned MaxResults = 8;
  localparam int unsigned CntW       = $clog2(MaxResults + 1);
  localparam int unsigned RepeatBit  = 0;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_REG   = 2'd1,
    CMD_UNREG = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_REGISTERED = 3'd0,
    KIND_FULL       = 3'd1,
    KIND_REMOVED    = 3'd2,
    KIND_NOT_FOUND  = 3'd3,
    KIND_EXPIRED    = 3'd4,
    KIND_IDLE_TICK  = 3'd5
  } kind_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] period;
    logic        repeat_req;
    logic [31:0] timer_id;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] handle;
    logic        pending_valid;
    logic [31:0] pending_id;
    logic [47:0] pending_delay;
    logic        last;
  } out_t;

endpackage

// ----- src/multi_timer_scheduler_core.sv -----
// Flow: a command scans the slots for a match, acts, then scans for the minimum; a
// tick rescans the slots after each expiry, up to 8 expiries, before the final result.
// Throughput: one command at a time in the engine, bounded by its slot scans;
// a two-entry queue takes new transfers while the engine works.
// Reset: asynchronous active low; clears time and slot valids, sets the id counter to 1.
// ----------------------------------------------------------------------------
// multi_timer_scheduler_core
// Timer table with register, unregister and tick commands.
// ----------------------------------------------------------------------------
module multi_timer_scheduler_core import mts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic q_valid, q_ready;
  in_t  q_data;

  mts_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  mts_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule

// ----- src/mts_front.sv -----
// ----------------------------------------------------------------------------
// mts_front
// Input stage: classify the command and queue it for the engine.
// ----------------------------------------------------------------------------
module mts_front import mts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic q_valid_o,
  input  logic q_ready_i,
  output in_t  q_data_o
);

  in_t  buf_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       rd_q, wr_q;
  logic       push, pop;
  in_t        cls;

  always_comb begin
    cls = in_data_i;
    if (in_data_i.cmd == CMD_REG && in_data_i.period == 32'd0) begin
      cls.period = 32'd1;
    end
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_data_o   = buf_q[rd_q];
  assign push = in_valid_i && in_ready_o;
  assign pop  = q_valid_o && q_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    if (pop && !push) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= cls;
  end

endmodule

// ----- src/mts_back.sv -----
// ----------------------------------------------------------------------------
// mts_back
// Timer engine: slot table, slot scans and result register.
// ----------------------------------------------------------------------------
module mts_back import mts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic q_valid_i,
  output logic q_ready_o,
  input  in_t  q_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SCAN, ST_ACT, ST_MIN, ST_EMIT, ST_WAIT
  } state_e;

  state_e            state_q;
  in_t               cmd_q;
  logic [NumSlots-1:0] valid_q;
  logic [31:0]       id_q     [NumSlots];
  logic [31:0]       period_q [NumSlots];
  logic [47:0]       exp_q    [NumSlots];
  logic              rep_q    [NumSlots];
  logic [47:0]       now_q;
  logic [31:0]       idc_q;
  logic [SlotW-1:0]  idx_q;
  logic              found_q;
  logic [SlotW-1:0]  hit_q;
  logic              bvalid_q;
  logic [SlotW-1:0]  best_q;
  logic [CntW-1:0]   n_q;
  logic [2:0]        kind_q;
  logic [31:0]       handle_q;
  logic              expire_q;
  out_t              out_q;
  logic              ov_q;

  logic scan_end;
  logic cand_better;
  logic [47:0] bexp;
  logic [31:0] bid;
  assign scan_end = (idx_q == SlotW'(NumSlots - 1));
  assign bexp = exp_q[best_q];
  assign bid  = id_q[best_q];
  assign cand_better = valid_q[idx_q] && (!bvalid_q || exp_q[idx_q] < bexp ||
                       (exp_q[idx_q] == bexp && id_q[idx_q] < bid));

  assign q_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= '0;
      now_q    <= '0;
      idc_q    <= 32'd1;
      ov_q     <= 1'b0;
      idx_q    <= '0;
      found_q  <= 1'b0;
      bvalid_q <= 1'b0;
      n_q      <= '0;
      expire_q <= 1'b0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            cmd_q    <= q_data_i;
            idx_q    <= '0;
            found_q  <= 1'b0;
            n_q      <= '0;
            expire_q <= 1'b0;
            if (q_data_i.cmd == CMD_TICK) begin
              now_q    <= now_q + 48'd1;
              bvalid_q <= 1'b0;
              state_q  <= ST_MIN;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (!found_q && ((cmd_q.cmd == CMD_REG && !valid_q[idx_q]) ||
              (cmd_q.cmd == CMD_UNREG && valid_q[idx_q] &&
               id_q[idx_q] == cmd_q.timer_id))) begin
            found_q <= 1'b1;
            hit_q   <= idx_q;
          end
          if (scan_end) state_q <= ST_ACT;
          else idx_q <= idx_q + SlotW'(1);
        end
        ST_ACT: begin
          expire_q <= 1'b0;
          handle_q <= '0;
          unique case (cmd_q.cmd)
            CMD_REG: begin
              if (found_q) begin
                valid_q[hit_q]  <= 1'b1;
                id_q[hit_q]     <= idc_q;
                period_q[hit_q] <= cmd_q.period;
                rep_q[hit_q]    <= cmd_q.repeat_req;
                exp_q[hit_q]    <= now_q + {16'd0, cmd_q.period};
                idc_q    <= (idc_q == 32'hFFFF_FFFF) ? 32'd1 : idc_q + 32'd1;
                kind_q   <= KIND_REGISTERED;
                handle_q <= idc_q;
              end else begin
                kind_q <= KIND_FULL;
              end
            end
            CMD_UNREG: begin
              if (found_q) begin
                valid_q[hit_q] <= 1'b0;
                kind_q   <= KIND_REMOVED;
                handle_q <= cmd_q.timer_id;
              end else begin
                kind_q <= KIND_NOT_FOUND;
              end
            end
            default: kind_q <= KIND_IDLE_TICK;
          endcase
          idx_q    <= '0;
          bvalid_q <= 1'b0;
          state_q  <= ST_MIN;
        end
        ST_MIN: begin
          if (cand_better) begin
            bvalid_q <= 1'b1;
            best_q   <= idx_q;
          end
          if (scan_end) state_q <= ST_EMIT;
          else idx_q <= idx_q + SlotW'(1);
        end
        ST_EMIT: begin
          if (!ov_q || out_ready_i) begin
            if (cmd_q.cmd == CMD_TICK && !expire_q) begin
              // decide the next tick event from the fresh minimum
              if (n_q != CntW'(MaxResults) && bvalid_q && bexp < now_q) begin
                if (rep_q[best_q]) exp_q[best_q] <= now_q + {16'd0, period_q[best_q]};
                else valid_q[best_q] <= 1'b0;
                // release the held expiry as a non-final transfer
                if (n_q != '0) ov_q <= 1'b1;
                kind_q   <= KIND_EXPIRED;
                handle_q <= bid;
                n_q      <= n_q + CntW'(1);
                expire_q <= 1'b1;
                idx_q    <= '0;
                bvalid_q <= 1'b0;
                state_q  <= ST_MIN;
              end else if (n_q == '0) begin
                kind_q   <= KIND_IDLE_TICK;
                handle_q <= '0;
                expire_q <= 1'b1;
                state_q  <= ST_WAIT;
              end else begin
                // previous expiry is held; mark it final and release it
                out_q.last <= 1'b1;
                ov_q       <= 1'b1;
                state_q    <= ST_IDLE;
              end
            end else begin
              state_q <= ST_WAIT;
            end
          end
        end
        ST_WAIT: begin
          if (!ov_q || out_ready_i) begin
            out_q.kind          <= kind_q;
            out_q.handle        <= handle_q;
            out_q.pending_valid <= bvalid_q;
            out_q.pending_id    <= bvalid_q ? bid : 32'd0;
            out_q.pending_delay <= !bvalid_q ? 48'd0 :
                                   (bexp < now_q) ? 48'd1 : bexp - now_q;
            ov_q <= 1'b1;
            if (cmd_q.cmd == CMD_TICK && kind_q == KIND_EXPIRED) begin
              out_q.last <= 1'b0;
              ov_q       <= 1'b0;
              expire_q   <= 1'b0;
              state_q    <= ST_EMIT;
            end else begin
              out_q.last <= 1'b1;
              state_q    <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= CntW'(MaxResults)) else $error("expiry count over cap");
  a_idc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idc_q != 32'd0) else $error("id counter hit zero");
`endif

endmodule
